// ----- rtl/utrs_pkg.sv -----
// ----------------------------------------------------------------------------
// utrs_pkg
// Shared types and constants of the UART transmit ring and interrupt service.
// ----------------------------------------------------------------------------
package utrs_pkg;

  localparam int unsigned LenW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 32;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 88;

  // Item kind carried on tuser.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  typedef enum logic [1:0] {
    WS_OK       = 2'd0,
    WS_BAD_LEN  = 2'd1,
    WS_NO_SPACE = 2'd2
  } wstat_e;

  // Input tdata, lowest field last.
  typedef struct packed {
    logic             pad;
    logic [ByteW-1:0] rx_byte;
    logic             tx_ready;
    logic             rx_ready;
    logic             overrun_error;
    logic             noise_error;
    logic             framing_error;
    logic             parity_error;
    logic [ByteW-1:0] tx_byte;
    logic [LenW-1:0]  burst_length;
    logic             burst_first;
  } in_data_t;

  // Output tdata, lowest field last.
  typedef struct packed {
    logic [1:0]       pad;
    logic [CntW-1:0]  line_error_total;
    logic [CntW-1:0]  tx_overflow_total;
    logic             tx_irq_enabled;
    logic [ByteW-1:0] tx_out_byte;
    logic             tx_valid;
    logic [ByteW-1:0] rx_event_byte;
    logic             rx_event;
    logic             error_event;
    wstat_e           write_status;
  } out_data_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ----- rtl/utrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// utrs_ctrl
// Handshake control: takes one request, runs its execute cycle, holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
module utrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output utrs_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // A new request is taken only when the output register is free by the
  // time the execute cycle loads it.
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.exec  = (state_q == S_EXEC);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/utrs_dp.sv -----
// ----------------------------------------------------------------------------
// utrs_dp
// Datapath: ring memory, ring indices, burst tracking, counters and the
// result register.
// ----------------------------------------------------------------------------
module utrs_dp #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utrs_pkg::cmd_t      cmd_i,
  input  logic                op_i,
  input  utrs_pkg::in_data_t  in_data_i,
  output utrs_pkg::out_data_t out_data_o
);

  localparam int unsigned IdxW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FreeW = IdxW + 1;
  localparam int unsigned CmpW  = utrs_pkg::LenW + 1;

  localparam logic [IdxW-1:0]  IdxLast   = IdxW'(RING_DEPTH - 1);
  localparam logic [FreeW-1:0] DepthFree = FreeW'(RING_DEPTH);

  logic [utrs_pkg::ByteW-1:0] mem_q [RING_DEPTH];
  logic [utrs_pkg::ByteW-1:0] rd_data_q;

  logic                       op_q;
  utrs_pkg::in_data_t         it_q;
  utrs_pkg::out_data_t        out_q, out_d;

  logic [IdxW-1:0]            wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]            rd_idx_q, rd_idx_d;
  logic                       tx_en_q, tx_en_d;
  logic [utrs_pkg::CntW-1:0]  ovf_cnt_q, ovf_cnt_d;
  logic [utrs_pkg::CntW-1:0]  err_cnt_q, err_cnt_d;
  logic [utrs_pkg::LenW-1:0]  burst_rem_q, burst_rem_d;
  logic                       burst_acc_q, burst_acc_d;

  logic                       mem_we;
  logic [FreeW-1:0]           free_raw;
  logic [FreeW-1:0]           free_space;
  logic [utrs_pkg::LenW-1:0]  len_m1;
  logic                       any_err;

  always_comb begin
    free_raw   = {1'b0, rd_idx_q} + DepthFree - {1'b0, wr_idx_q} - FreeW'(1);
    free_space = (free_raw >= DepthFree) ? (free_raw - DepthFree) : free_raw;
  end

  assign len_m1  = it_q.burst_length - utrs_pkg::LenW'(1);
  assign any_err = it_q.parity_error | it_q.framing_error
                 | it_q.noise_error | it_q.overrun_error;

  always_comb begin
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    tx_en_d     = tx_en_q;
    ovf_cnt_d   = ovf_cnt_q;
    err_cnt_d   = err_cnt_q;
    burst_rem_d = burst_rem_q;
    burst_acc_d = burst_acc_q;
    mem_we      = 1'b0;

    out_d              = '0;
    out_d.write_status = utrs_pkg::WS_OK;

    if (op_q == utrs_pkg::OP_WRITE) begin
      if (it_q.burst_first) begin
        if (it_q.burst_length == '0) begin
          out_d.write_status = utrs_pkg::WS_BAD_LEN;
          burst_rem_d        = '0;
          burst_acc_d        = 1'b0;
        end else if (CmpW'(it_q.burst_length) > CmpW'(free_space)) begin
          out_d.write_status = utrs_pkg::WS_NO_SPACE;
          if (ovf_cnt_q != '1) begin
            ovf_cnt_d = ovf_cnt_q + utrs_pkg::CntW'(1);
          end
          burst_rem_d = len_m1;
          burst_acc_d = 1'b0;
        end else begin
          mem_we      = 1'b1;
          burst_rem_d = len_m1;
          burst_acc_d = (len_m1 != '0);
          if (len_m1 == '0) begin
            tx_en_d = 1'b1;
          end
        end
      end else if (burst_rem_q != '0) begin
        burst_rem_d = burst_rem_q - utrs_pkg::LenW'(1);
        if (burst_acc_q) begin
          mem_we = 1'b1;
          if (burst_rem_d == '0) begin
            tx_en_d     = 1'b1;
            burst_acc_d = 1'b0;
          end
        end
      end
      if (mem_we) begin
        wr_idx_d = (wr_idx_q == IdxLast) ? '0 : wr_idx_q + IdxW'(1);
      end
    end else begin
      if (any_err) begin
        if (err_cnt_q != '1) begin
          err_cnt_d = err_cnt_q + utrs_pkg::CntW'(1);
        end
        out_d.error_event = 1'b1;
      end else if (it_q.rx_ready) begin
        out_d.rx_event      = 1'b1;
        out_d.rx_event_byte = it_q.rx_byte;
      end
      if (it_q.tx_ready && tx_en_q) begin
        if (rd_idx_q != wr_idx_q) begin
          out_d.tx_valid    = 1'b1;
          out_d.tx_out_byte = rd_data_q;
          rd_idx_d = (rd_idx_q == IdxLast) ? '0 : rd_idx_q + IdxW'(1);
        end else begin
          tx_en_d = 1'b0;
        end
      end
    end

    out_d.tx_irq_enabled    = tx_en_d;
    out_d.tx_overflow_total = ovf_cnt_d;
    out_d.line_error_total  = err_cnt_d;
  end

  // The slot at the read index is read every cycle; by the execute cycle it
  // holds the byte for a possible pop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem_q[wr_idx_q] <= it_q.tx_byte;
    end
    rd_data_q <= mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      it_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      tx_en_q     <= 1'b0;
      ovf_cnt_q   <= '0;
      err_cnt_q   <= '0;
      burst_rem_q <= '0;
      burst_acc_q <= 1'b0;
    end else if (cmd_i.exec) begin
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      tx_en_q     <= tx_en_d;
      ovf_cnt_q   <= ovf_cnt_d;
      err_cnt_q   <= err_cnt_d;
      burst_rem_q <= burst_rem_d;
      burst_acc_q <= burst_acc_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/uart_tx_ring_irq_service.sv -----
// ----------------------------------------------------------------------------
// uart_tx_ring_irq_service
// UART transmit ring with all-or-nothing burst admission and the interrupt
// service step, one result per request.
// ----------------------------------------------------------------------------
// Each request is handled in the cycle it is accepted, in which the ring
// slot at the read index is fetched through the memory's registered read
// port, and in the execute cycle that updates the ring, the counters and
// the result register. A new request waits until the previous one has left
// its execute cycle; a result left waiting holds off the next request until
// the result is taken. The ring needs no clearing after reset, so requests
// are accepted from the first cycle out of reset.
module uart_tx_ring_irq_service #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: burst_first, burst_length[16], tx_byte[8], parity_error,
  // framing_error, noise_error, overrun_error, rx_ready, tx_ready,
  // rx_byte[8], zero pad.
  input  logic [utrs_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: op (0 write burst byte, 1 service event).
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: write_status[2], error_event, rx_event, rx_event_byte[8],
  // tx_valid, tx_out_byte[8], tx_irq_enabled, tx_overflow_total[32],
  // line_error_total[32], zero pad.
  output logic [utrs_pkg::OutDataW-1:0] m_axis_tdata_o
);

  utrs_pkg::cmd_t      cmd;
  utrs_pkg::out_data_t out_data;

  utrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  utrs_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (s_axis_tuser_i),
    .in_data_i  (utrs_pkg::in_data_t'(s_axis_tdata_i)),
    .out_data_o (out_data)
  );

  assign m_axis_tdata_o = out_data;

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // The output register is always free in the execute cycle.
  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !m_axis_tvalid_o)
    else $error("output register busy during execute cycle");

  // One request at a time.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("request accepted during execute cycle");

  // A rising result valid follows an accepted request through the execute state.
  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_acc, 2))
    else $error("result without matching request");

  // A byte is sent only while the transmit interrupt stays enabled.
  a_pop_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_data.tx_valid) |-> out_data.tx_irq_enabled)
    else $error("byte sent with transmit interrupt disabled");

endmodule

// ----- tb/uart_tx_ring_irq_service_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_tx_ring_irq_service_tb
// Self-checking bench for the UART transmit ring and interrupt service block.
// A behavioral copy of the ring, burst admission and service step predicts
// one result per request. The checker compares every result field by field
// in arrival order. Stimulus starts with directed corner cases and a full
// ring, then runs mixed burst and service traffic with random stalls on both
// streams. It ends with a stretch of traffic without any stalls.
// ----------------------------------------------------------------------------
module uart_tx_ring_irq_service_tb;

  localparam int unsigned RingDepth = 256;
  localparam int unsigned IdxW      = $clog2(RingDepth);

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  utrs_pkg::in_data_t  s_tdata  = '0;
  logic                s_tuser  = utrs_pkg::OP_WRITE;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  utrs_pkg::out_data_t m_tdata;

  uart_tx_ring_irq_service #(
    .RING_DEPTH(RingDepth)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the block.
  logic [utrs_pkg::ByteW-1:0] ring_mem [RingDepth];
  logic [IdxW-1:0]            ring_wr       = '0;
  logic [IdxW-1:0]            ring_rd       = '0;
  logic                       tx_enable     = 1'b0;
  logic [utrs_pkg::CntW-1:0]  overflow_cnt  = '0;
  logic [utrs_pkg::CntW-1:0]  line_err_cnt  = '0;
  logic [utrs_pkg::LenW-1:0]  burst_left    = '0;
  logic                       burst_storing = 1'b0;

  utrs_pkg::out_data_t due_results[$];
  int unsigned requests_sent  = 0;
  int unsigned mismatch_count = 0;
  bit          src_idle_on    = 1'b1;
  bit          snk_idle_on    = 1'b1;
  int unsigned sink_hold      = 0;

  function automatic logic [utrs_pkg::CntW-1:0] sat_bump(
      input logic [utrs_pkg::CntW-1:0] v);
    return (v == '1) ? v : v + utrs_pkg::CntW'(1);
  endfunction

  function automatic int unsigned ring_free();
    logic [IdxW-1:0] gap;
    gap = ring_rd - ring_wr - IdxW'(1);
    return 32'(gap);
  endfunction

  task automatic ring_push(input logic [utrs_pkg::ByteW-1:0] data);
    ring_mem[ring_wr] = data;
    ring_wr = ring_wr + IdxW'(1);
  endtask

  // One request through the predicted block; returns the result it causes.
  task automatic service_ring_step(input logic op, input utrs_pkg::in_data_t req,
                                   output utrs_pkg::out_data_t res);
    res = '0;
    res.write_status = utrs_pkg::WS_OK;
    if (op == utrs_pkg::OP_WRITE) begin
      if (req.burst_first) begin
        if (req.burst_length == '0) begin
          res.write_status = utrs_pkg::WS_BAD_LEN;
          burst_left = '0;
          burst_storing = 1'b0;
        end else if (32'(req.burst_length) > ring_free()) begin
          // Refused as a whole; the rest of the burst is swallowed.
          res.write_status = utrs_pkg::WS_NO_SPACE;
          overflow_cnt = sat_bump(overflow_cnt);
          burst_left = req.burst_length - utrs_pkg::LenW'(1);
          burst_storing = 1'b0;
        end else begin
          ring_push(req.tx_byte);
          burst_left = req.burst_length - utrs_pkg::LenW'(1);
          burst_storing = 1'b1;
          if (burst_left == '0) begin
            tx_enable = 1'b1;
            burst_storing = 1'b0;
          end
        end
      end else if (burst_left != '0) begin
        burst_left = burst_left - utrs_pkg::LenW'(1);
        if (burst_storing) begin
          ring_push(req.tx_byte);
          if (burst_left == '0) begin
            tx_enable = 1'b1;
            burst_storing = 1'b0;
          end
        end
      end
    end else begin
      if (req.parity_error | req.framing_error | req.noise_error | req.overrun_error) begin
        line_err_cnt = sat_bump(line_err_cnt);
        res.error_event = 1'b1;
      end else if (req.rx_ready) begin
        res.rx_event = 1'b1;
        res.rx_event_byte = req.rx_byte;
      end
      if (req.tx_ready && tx_enable) begin
        if (ring_rd != ring_wr) begin
          res.tx_valid = 1'b1;
          res.tx_out_byte = ring_mem[ring_rd];
          ring_rd = ring_rd + IdxW'(1);
        end else begin
          tx_enable = 1'b0;
        end
      end
    end
    res.tx_irq_enabled = tx_enable;
    res.tx_overflow_total = overflow_cnt;
    res.line_error_total = line_err_cnt;
  endtask

  function automatic utrs_pkg::in_data_t write_req(input logic first,
      input logic [utrs_pkg::LenW-1:0] len, input logic [utrs_pkg::ByteW-1:0] data);
    utrs_pkg::in_data_t r;
    r = utrs_pkg::in_data_t'(utrs_pkg::InDataW'({$urandom, $urandom}));
    r.pad = 1'b0;
    r.burst_first = first;
    r.burst_length = len;
    r.tx_byte = data;
    return r;
  endfunction

  function automatic utrs_pkg::in_data_t service_req(input logic [3:0] errs,
      input logic rx_rdy, input logic tx_rdy, input logic [utrs_pkg::ByteW-1:0] rxb);
    utrs_pkg::in_data_t r;
    r = utrs_pkg::in_data_t'(utrs_pkg::InDataW'({$urandom, $urandom}));
    r.pad = 1'b0;
    {r.overrun_error, r.noise_error, r.framing_error, r.parity_error} = errs;
    r.rx_ready = rx_rdy;
    r.tx_ready = tx_rdy;
    r.rx_byte = rxb;
    return r;
  endfunction

  // Presents one request, waits for the handshake and records its result.
  task automatic send_request(input logic op, input utrs_pkg::in_data_t req);
    utrs_pkg::out_data_t res;
    s_tvalid <= 1'b1;
    s_tdata <= req;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    service_ring_step(op, req, res);
    due_results.push_back(res);
    requests_sent++;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_burst(input int unsigned len, input int unsigned n_bytes);
    send_request(utrs_pkg::OP_WRITE,
                 write_req(1'b1, utrs_pkg::LenW'(len), utrs_pkg::ByteW'($urandom)));
    for (int unsigned i = 1; i < n_bytes; i++) begin
      send_request(utrs_pkg::OP_WRITE, write_req(1'b0, utrs_pkg::LenW'($urandom),
                                                 utrs_pkg::ByteW'($urandom)));
    end
  endtask

  task automatic send_random_service();
    logic [3:0] errs;
    errs = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    send_request(utrs_pkg::OP_SERVICE,
                 service_req(errs, 1'($urandom), $urandom_range(0, 9) < 7,
                             utrs_pkg::ByteW'($urandom)));
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Result checker: every taken result is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    utrs_pkg::out_data_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'd1, 32'd0);
      end else begin
        want = due_results.pop_front();
        check_field("write_status", 32'(m_tdata.write_status), 32'(want.write_status));
        check_field("error_event", 32'(m_tdata.error_event), 32'(want.error_event));
        check_field("rx_event", 32'(m_tdata.rx_event), 32'(want.rx_event));
        check_field("rx_event_byte", 32'(m_tdata.rx_event_byte), 32'(want.rx_event_byte));
        check_field("tx_valid", 32'(m_tdata.tx_valid), 32'(want.tx_valid));
        check_field("tx_out_byte", 32'(m_tdata.tx_out_byte), 32'(want.tx_out_byte));
        check_field("tx_irq_enabled", 32'(m_tdata.tx_irq_enabled), 32'(want.tx_irq_enabled));
        check_field("tx_overflow_total", m_tdata.tx_overflow_total, want.tx_overflow_total);
        check_field("line_error_total", m_tdata.line_error_total, want.line_error_total);
      end
    end
  end

  // Result sink with random stall bursts.
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_tready <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
      sink_hold <= $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic test_service_after_reset();
    // Transmitter ready but nothing enabled: only the counters come back.
    send_request(utrs_pkg::OP_SERVICE, service_req(4'd0, 1'b0, 1'b1, 8'h00));
  endtask

  task automatic test_write_corner_cases();
    send_request(utrs_pkg::OP_WRITE, write_req(1'b0, 16'h1234, 8'hAA));   // stray byte
    send_request(utrs_pkg::OP_WRITE, write_req(1'b1, 16'h0000, 8'h55));   // zero length
    send_request(utrs_pkg::OP_WRITE, write_req(1'b1, 16'hFFFF, 8'h00));   // far too large
    send_request(utrs_pkg::OP_WRITE, write_req(1'b0, 16'h0000, 8'hFF));
    send_request(utrs_pkg::OP_WRITE, write_req(1'b0, 16'hFFFF, 8'h00));
    send_request(utrs_pkg::OP_WRITE, write_req(1'b1, 16'h0001, 8'hFF));   // single byte burst
    send_request(utrs_pkg::OP_WRITE, write_req(1'b1, 16'h0003, 8'h01));
    send_request(utrs_pkg::OP_WRITE, write_req(1'b0, 16'h0000, 8'h02));
    // A new first byte abandons the open burst; its stored bytes stay.
    send_request(utrs_pkg::OP_WRITE, write_req(1'b1, 16'h0002, 8'h80));
    send_request(utrs_pkg::OP_WRITE, write_req(1'b0, 16'h0000, 8'h7F));
  endtask

  task automatic test_service_paths();
    send_request(utrs_pkg::OP_SERVICE, service_req(4'b1111, 1'b1, 1'b1, 8'hFF));
    send_request(utrs_pkg::OP_SERVICE, service_req(4'b0000, 1'b1, 1'b1, 8'hFF));
    for (int i = 0; i < 4; i++) begin
      send_request(utrs_pkg::OP_SERVICE, service_req(4'b0001 << i, 1'b1, 1'b0, 8'hA5));
    end
    send_request(utrs_pkg::OP_SERVICE, service_req(4'b0000, 1'b1, 1'b0, 8'h00));
    // Drain the ring until the empty ring clears the enable.
    while (tx_enable) begin
      send_request(utrs_pkg::OP_SERVICE, service_req(4'b0000, 1'b0, 1'b1, 8'h00));
    end
  endtask

  task automatic test_ring_capacity();
    send_burst(ring_free(), ring_free());
    send_burst(1, 1);
    while (tx_enable) begin
      send_request(utrs_pkg::OP_SERVICE,
                   service_req(4'd0, 1'($urandom), 1'b1, utrs_pkg::ByteW'($urandom)));
    end
  endtask

  task automatic test_mixed_traffic(input int unsigned stop_at, input bit vary_idle);
    int unsigned pick;
    int unsigned len;
    int unsigned space;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      space = ring_free();
      if (pick < 40) begin
        len = $urandom_range(1, 12);
        if (space > 0 && $urandom_range(0, 9) == 0) len = $urandom_range(1, space);
        send_burst(len, len);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 8)) send_random_service();
      end else if (pick < 86) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(space + 1, 65535)
                                          : space + $urandom_range(1, 8);
        send_burst(len, $urandom_range(1, 4));
      end else if (pick < 90) begin
        send_burst(0, $urandom_range(1, 3));
      end else if (pick < 95) begin
        len = $urandom_range(3, 20);
        send_burst(len, $urandom_range(1, len - 1));
      end else begin
        send_request(utrs_pkg::OP_WRITE, write_req(1'b0, utrs_pkg::LenW'($urandom),
                                                   utrs_pkg::ByteW'($urandom)));
      end
      if (vary_idle) begin
        if ($urandom_range(0, 24) == 0) src_idle_on = !src_idle_on;
        if ($urandom_range(0, 24) == 0) snk_idle_on = !snk_idle_on;
      end
    end
  endtask

  task automatic test_quiet_traffic(input int unsigned n_requests);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    test_mixed_traffic(requests_sent + n_requests, 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_service_after_reset();
    test_write_corner_cases();
    test_service_paths();
    test_ring_capacity();
    test_mixed_traffic(1300, 1'b1);
    test_quiet_traffic(150);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** uart_tx_ring_irq_service: PASSED **");
    end else begin
      $display("** uart_tx_ring_irq_service: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("** uart_tx_ring_irq_service: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/utrs_pkg.sv
rtl/utrs_ctrl.sv
rtl/utrs_dp.sv
rtl/uart_tx_ring_irq_service.sv
tb/uart_tx_ring_irq_service_tb.sv
